// File: src/tcb_pkg.sv
// Shared constants, command codes and state types for the text cell buffer.
`default_nettype none
package tcb_pkg;

  localparam int DEF_COLS      = 80;
  localparam int DEF_ROWS      = 24;
  localparam int DEF_ATTR_BITS = 8;

  localparam logic [7:0] BLANK_CHAR = 8'h20;

  localparam logic [4:0] CMD_PUT       = 5'd0;
  localparam logic [4:0] CMD_PUT_AT    = 5'd1;
  localparam logic [4:0] CMD_CR        = 5'd2;
  localparam logic [4:0] CMD_TAB       = 5'd3;
  localparam logic [4:0] CMD_BS        = 5'd4;
  localparam logic [4:0] CMD_MOVE      = 5'd5;
  localparam logic [4:0] CMD_SETPOS    = 5'd6;
  localparam logic [4:0] CMD_LF        = 5'd7;
  localparam logic [4:0] CMD_RLF       = 5'd8;
  localparam logic [4:0] CMD_REGION    = 5'd9;
  localparam logic [4:0] CMD_INS_LINES = 5'd10;
  localparam logic [4:0] CMD_DEL_LINES = 5'd11;
  localparam logic [4:0] CMD_CLR_ROW   = 5'd12;
  localparam logic [4:0] CMD_DEL_CHARS = 5'd13;
  localparam logic [4:0] CMD_ERASE     = 5'd14;
  localparam logic [4:0] CMD_INS_CHARS = 5'd15;
  localparam logic [4:0] CMD_READ      = 5'd16;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic [0:0] CFG_INSERT_MODE = 1'd0;
  localparam logic [0:0] CFG_ATTRIBUTE   = 1'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_RUN,
    ST_SCROLL,
    ST_W_RD,
    ST_W_WR,
    ST_W_FILL,
    ST_RD0,
    ST_RD1
  } state_t;

  typedef enum logic [3:0] {
    PH_WRAP,
    PH_INS_CHECK,
    PH_INS_COPY,
    PH_INS_FILL,
    PH_PUT,
    PH_DEL_COPY,
    PH_DEL_FILL,
    PH_LINES,
    PH_DONE
  } phase_t;

endpackage
`default_nettype wire

// File: src/tcb_cell_mem.sv
// Cell memory: one write port, one registered read port, clearing sweep after reset.
`default_nettype none
module tcb_cell_mem #(
  parameter int DEPTH = 1920,
  parameter int DW = 17,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  output logic          busy,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic          clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  assign busy = clearing;

endmodule
`default_nettype wire

// File: src/tcb_ctrl.sv
// Command sequencer: cursor, scroll region, cell walks and result register.
`default_nettype none
module tcb_ctrl #(
  parameter int COLS = tcb_pkg::DEF_COLS,
  parameter int ROWS = tcb_pkg::DEF_ROWS,
  parameter int ATTR_BITS = tcb_pkg::DEF_ATTR_BITS,
  localparam int AW = $clog2(ROWS * COLS),
  localparam int DW = 9 + ATTR_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [4:0]    command,
  input  logic [7:0]    char_code,
  input  logic [7:0]    attribute_value,
  input  logic [7:0]    column,
  input  logic [7:0]    row,
  input  logic [7:0]    bottom_row,
  input  logic [7:0]    count,
  input  logic [1:0]    direction,
  input  logic          option_flag,
  input  logic          use_cursor_row,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [6:0]    cursor_column,
  output logic [4:0]    cursor_row,
  output logic [7:0]    cell_char,
  output logic [7:0]    cell_attribute,
  output logic          cell_dirty,
  input  logic          insert_mode,
  input  logic [7:0]    current_attribute,
  input  logic          mem_busy,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [DW-1:0] mem_wdata,
  output logic          mem_re,
  output logic [AW-1:0] mem_raddr,
  input  logic [DW-1:0] mem_rdata
);
  import tcb_pkg::*;

  localparam int XW = $clog2(COLS + 1);
  localparam int YW = $clog2(ROWS);
  localparam int TW = 10;
  localparam logic [TW-1:0] COLS_T = TW'(COLS);
  localparam logic [TW-1:0] ROWS_T = TW'(ROWS);
  localparam logic [AW-1:0] COLS_A = AW'(COLS);

  typedef struct packed {
    logic [YW-1:0]        dy;
    logic [YW-1:0]        sy;
    logic [XW-1:0]        x;
    logic [XW-1:0]        sx;
    logic [XW-1:0]        xend;
    logic                 dec;
    logic [7:0]           chr;
    logic [ATTR_BITS-1:0] attr;
  } walk_t;

  function automatic logic [AW-1:0] cell_addr(input logic [YW-1:0] y, input logic [XW-1:0] x);
    cell_addr = AW'(AW'(y) * COLS_A + AW'(x));
  endfunction

  state_t state, state_next;
  phase_t phase, phase_next;
  logic [XW-1:0] cur_col, cur_col_next;
  logic [YW-1:0] cur_line, cur_line_next;
  logic [YW-1:0] rtop, rtop_next;
  logic [YW-1:0] rbot, rbot_next;
  logic          out_valid_next;

  logic [4:0] cmd_r, cmd_r_next;
  logic [7:0] ch_r, ch_r_next;
  logic [7:0] av_r, av_r_next;
  logic [7:0] col_r, col_r_next;
  logic [7:0] row_r, row_r_next;
  logic [7:0] bot_r, bot_r_next;
  logic [7:0] cnt_r, cnt_r_next;
  logic [1:0] dir_r, dir_r_next;
  logic       opt_r, opt_r_next;
  logic       ucr_r, ucr_r_next;
  logic [XW-1:0] ins_n, ins_n_next;
  logic [7:0] line_cnt, line_cnt_next;
  logic       sc_up, sc_up_next;
  logic [YW-1:0] sc_y, sc_y_next;
  logic [YW-1:0] sc_end, sc_end_next;
  walk_t      walk, walk_next;
  logic       w_ret, w_ret_next;
  logic [7:0] rd_char, rd_char_next;
  logic [7:0] rd_attr, rd_attr_next;
  logic       rd_dirty, rd_dirty_next;
  logic [XW-1:0] out_col, out_col_next;
  logic [YW-1:0] out_row, out_row_next;
  logic [7:0] out_char, out_char_next;
  logic [7:0] out_attr, out_attr_next;
  logic       out_dirty, out_dirty_next;

  logic [TW-1:0] c_t, l_t, n_t, cnt_t;
  logic          adv_scroll, rec_scroll;
  logic [YW-1:0] adv_line, rec_line;
  logic [XW-1:0] col_clamp;
  logic [TW-1:0] span_n;
  logic [TW-1:0] tab_v, tab_r;
  logic          tab_wrap;
  logic [TW-1:0] tab_col;
  logic [TW-1:0] mv_n, mv_c;
  logic [TW-1:0] sp_c, sp_r;
  logic [TW-1:0] rg_t, rg_b;
  logic [TW-1:0] cl_y, cl_lo, cl_hi;
  logic [TW-1:0] er_end;
  logic          at_ok;
  logic [ATTR_BITS-1:0] cur_attr;

  always_comb begin
    c_t = TW'(cur_col);
    l_t = TW'(cur_line);
    n_t = TW'(ins_n);
    cnt_t = TW'(cnt_r);
    cur_attr = ATTR_BITS'(current_attribute);
    adv_scroll = (cur_line == rbot);
    adv_line = (l_t < ROWS_T - 1'b1) ? YW'(l_t + 1'b1) : cur_line;
    rec_scroll = (cur_line == rtop);
    rec_line = (cur_line != '0) ? YW'(l_t - 1'b1) : cur_line;
    col_clamp = (c_t >= COLS_T) ? XW'(COLS - 1) : cur_col;
    span_n = (cnt_t > COLS_T - c_t) ? COLS_T - c_t : cnt_t;
    tab_v = c_t + 1'b1;
    tab_r = (tab_v + TW'(7)) & ~TW'(7);
    tab_wrap = (tab_v > COLS_T) || ((tab_v[2:0] != 3'd0) && (tab_r >= COLS_T));
    tab_col = (tab_v[2:0] == 3'd0) ? tab_v : tab_r;
    mv_n = (cnt_r == 8'd0) ? TW'(1) : cnt_t;
    mv_c = TW'(col_clamp);
    sp_c = (col_r == 8'd0) ? '0 : TW'(col_r) - 1'b1;
    if (sp_c >= COLS_T) sp_c = COLS_T - 1'b1;
    sp_r = (row_r == 8'd0) ? '0 : TW'(row_r) - 1'b1;
    if (sp_r >= ROWS_T) sp_r = ROWS_T - 1'b1;
    rg_t = (row_r == 8'd0) ? '0 : TW'(row_r) - 1'b1;
    rg_b = (bot_r == 8'd0 || TW'(bot_r) > ROWS_T) ? ROWS_T - 1'b1 : TW'(bot_r) - 1'b1;
    cl_y = ucr_r ? l_t : TW'(row_r);
    cl_lo = opt_r ? '0 : c_t;
    cl_hi = (opt_r && c_t < COLS_T) ? c_t : COLS_T - 1'b1;
    er_end = (c_t + cnt_t - 1'b1 >= COLS_T) ? COLS_T - 1'b1 : c_t + cnt_t - 1'b1;
    at_ok = (TW'(col_r) < COLS_T) && (TW'(row_r) < ROWS_T);
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    cur_col_next = cur_col;
    cur_line_next = cur_line;
    rtop_next = rtop;
    rbot_next = rbot;
    out_valid_next = out_valid;
    cmd_r_next = cmd_r;
    ch_r_next = ch_r;
    av_r_next = av_r;
    col_r_next = col_r;
    row_r_next = row_r;
    bot_r_next = bot_r;
    cnt_r_next = cnt_r;
    dir_r_next = dir_r;
    opt_r_next = opt_r;
    ucr_r_next = ucr_r;
    ins_n_next = ins_n;
    line_cnt_next = line_cnt;
    sc_up_next = sc_up;
    sc_y_next = sc_y;
    sc_end_next = sc_end;
    walk_next = walk;
    w_ret_next = w_ret;
    rd_char_next = rd_char;
    rd_attr_next = rd_attr;
    rd_dirty_next = rd_dirty;
    out_col_next = out_col;
    out_row_next = out_row;
    out_char_next = out_char;
    out_attr_next = out_attr;
    out_dirty_next = out_dirty;

    if (out_valid && !out_stall) out_valid_next = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd_r_next = command;
          ch_r_next = char_code;
          av_r_next = attribute_value;
          col_r_next = column;
          row_r_next = row;
          bot_r_next = bottom_row;
          cnt_r_next = count;
          dir_r_next = direction;
          opt_r_next = option_flag;
          ucr_r_next = use_cursor_row;
          rd_char_next = '0;
          rd_attr_next = '0;
          rd_dirty_next = 1'b0;
          state_next = ST_START;
        end
      end
      ST_START: begin
        w_ret_next = 1'b0;
        state_next = ST_RUN;
        phase_next = PH_DONE;
        case (cmd_r)
          CMD_PUT: phase_next = PH_WRAP;
          CMD_PUT_AT: if (at_ok) phase_next = PH_INS_CHECK;
          CMD_CR: cur_col_next = '0;
          CMD_TAB: begin
            if (tab_wrap) begin
              cur_col_next = '0;
              if (adv_scroll) begin
                sc_up_next = 1'b1;
                sc_y_next = rtop;
                sc_end_next = rbot;
                state_next = ST_SCROLL;
              end else begin
                cur_line_next = adv_line;
              end
            end else begin
              cur_col_next = XW'(tab_col);
            end
          end
          CMD_BS: if (cur_col != '0) cur_col_next = XW'(c_t - 1'b1);
          CMD_MOVE: begin
            cur_col_next = col_clamp;
            case (dir_r)
              DIR_UP: cur_line_next = (mv_n > l_t) ? '0 : YW'(l_t - mv_n);
              DIR_DOWN: cur_line_next = (l_t + mv_n >= ROWS_T) ? YW'(ROWS - 1) : YW'(l_t + mv_n);
              DIR_LEFT: cur_col_next = (mv_n > mv_c) ? '0 : XW'(mv_c - mv_n);
              default: cur_col_next = (mv_c + mv_n >= COLS_T) ? XW'(COLS - 1) : XW'(mv_c + mv_n);
            endcase
          end
          CMD_SETPOS: begin
            cur_col_next = XW'(sp_c);
            cur_line_next = YW'(sp_r);
          end
          CMD_LF: begin
            cur_col_next = col_clamp;
            if (adv_scroll) begin
              sc_up_next = 1'b1;
              sc_y_next = rtop;
              sc_end_next = rbot;
              state_next = ST_SCROLL;
            end else begin
              cur_line_next = adv_line;
            end
          end
          CMD_RLF: begin
            cur_col_next = col_clamp;
            if (rec_scroll) begin
              sc_up_next = 1'b0;
              sc_y_next = rbot;
              sc_end_next = rtop;
              state_next = ST_SCROLL;
            end else begin
              cur_line_next = rec_line;
            end
          end
          CMD_REGION: begin
            if (rg_t < rg_b) begin
              rtop_next = YW'(rg_t);
              rbot_next = YW'(rg_b);
            end
            cur_col_next = '0;
            cur_line_next = '0;
          end
          CMD_INS_LINES, CMD_DEL_LINES: begin
            line_cnt_next = cnt_r;
            phase_next = PH_LINES;
          end
          CMD_CLR_ROW: begin
            if (cl_y < ROWS_T && cl_lo <= cl_hi) begin
              walk_next.dy = YW'(cl_y);
              walk_next.x = XW'(cl_lo);
              walk_next.xend = XW'(cl_hi);
              walk_next.dec = 1'b0;
              walk_next.chr = BLANK_CHAR;
              walk_next.attr = '0;
              state_next = ST_W_FILL;
            end
          end
          CMD_DEL_CHARS: begin
            if (c_t < COLS_T) begin
              ins_n_next = XW'(span_n);
              phase_next = PH_DEL_COPY;
            end
          end
          CMD_ERASE: begin
            if (c_t < COLS_T && cnt_r != 8'd0) begin
              walk_next.dy = cur_line;
              walk_next.x = cur_col;
              walk_next.xend = XW'(er_end);
              walk_next.dec = 1'b0;
              walk_next.chr = BLANK_CHAR;
              walk_next.attr = cur_attr;
              state_next = ST_W_FILL;
            end
          end
          CMD_INS_CHARS: begin
            if (c_t < COLS_T) begin
              ins_n_next = XW'(span_n);
              phase_next = PH_INS_COPY;
            end
          end
          CMD_READ: if (at_ok) state_next = ST_RD0;
          default: phase_next = PH_DONE;
        endcase
      end
      ST_RUN: begin
        w_ret_next = 1'b0;
        case (phase)
          PH_WRAP: begin
            phase_next = PH_INS_CHECK;
            if (c_t >= COLS_T) begin
              cur_col_next = '0;
              if (adv_scroll) begin
                sc_up_next = 1'b1;
                sc_y_next = rtop;
                sc_end_next = rbot;
                state_next = ST_SCROLL;
              end else begin
                cur_line_next = adv_line;
              end
            end
          end
          PH_INS_CHECK: begin
            if (insert_mode && !opt_r && c_t < COLS_T) begin
              ins_n_next = XW'(1);
              phase_next = PH_INS_COPY;
            end else begin
              phase_next = PH_PUT;
            end
          end
          PH_INS_COPY: begin
            phase_next = PH_INS_FILL;
            if (c_t + n_t < COLS_T) begin
              walk_next.dy = cur_line;
              walk_next.sy = cur_line;
              walk_next.x = XW'(COLS - 1);
              walk_next.sx = XW'(COLS_T - 1'b1 - n_t);
              walk_next.xend = XW'(c_t + n_t);
              walk_next.dec = 1'b1;
              state_next = ST_W_RD;
            end
          end
          PH_INS_FILL: begin
            phase_next = (cmd_r == CMD_INS_CHARS) ? PH_DONE : PH_PUT;
            if (ins_n != '0) begin
              walk_next.dy = cur_line;
              walk_next.x = cur_col;
              walk_next.xend = XW'(c_t + n_t - 1'b1);
              walk_next.dec = 1'b0;
              walk_next.chr = BLANK_CHAR;
              walk_next.attr = cur_attr;
              state_next = ST_W_FILL;
            end
          end
          PH_PUT: begin
            phase_next = PH_DONE;
            walk_next.dec = 1'b0;
            walk_next.chr = ch_r;
            if (cmd_r == CMD_PUT) begin
              walk_next.dy = cur_line;
              walk_next.x = cur_col;
              walk_next.xend = cur_col;
              walk_next.attr = cur_attr;
              cur_col_next = XW'(c_t + 1'b1);
            end else begin
              walk_next.dy = YW'(row_r);
              walk_next.x = XW'(col_r);
              walk_next.xend = XW'(col_r);
              walk_next.attr = ATTR_BITS'(av_r);
            end
            state_next = ST_W_FILL;
          end
          PH_DEL_COPY: begin
            phase_next = PH_DEL_FILL;
            if (c_t + n_t < COLS_T) begin
              walk_next.dy = cur_line;
              walk_next.sy = cur_line;
              walk_next.x = cur_col;
              walk_next.sx = XW'(c_t + n_t);
              walk_next.xend = XW'(COLS_T - 1'b1 - n_t);
              walk_next.dec = 1'b0;
              state_next = ST_W_RD;
            end
          end
          PH_DEL_FILL: begin
            phase_next = PH_DONE;
            if (ins_n != '0) begin
              walk_next.dy = cur_line;
              walk_next.x = XW'(COLS_T - n_t);
              walk_next.xend = XW'(COLS - 1);
              walk_next.dec = 1'b0;
              walk_next.chr = BLANK_CHAR;
              walk_next.attr = cur_attr;
              state_next = ST_W_FILL;
            end
          end
          PH_LINES: begin
            if (line_cnt != 8'd0) begin
              line_cnt_next = line_cnt - 1'b1;
              sc_up_next = (cmd_r == CMD_DEL_LINES);
              sc_y_next = (cmd_r == CMD_DEL_LINES) ? cur_line : YW'(ROWS - 1);
              sc_end_next = (cmd_r == CMD_DEL_LINES) ? YW'(ROWS - 1) : cur_line;
              state_next = ST_SCROLL;
            end else begin
              phase_next = PH_DONE;
            end
          end
          default: begin
            if (!out_valid || !out_stall) begin
              out_valid_next = 1'b1;
              out_col_next = cur_col;
              out_row_next = cur_line;
              out_char_next = rd_char;
              out_attr_next = rd_attr;
              out_dirty_next = rd_dirty;
              state_next = ST_IDLE;
            end
          end
        endcase
      end
      ST_SCROLL: begin
        walk_next.x = '0;
        walk_next.sx = '0;
        walk_next.xend = XW'(COLS - 1);
        walk_next.dec = 1'b0;
        if (sc_y != sc_end) begin
          walk_next.dy = sc_y;
          walk_next.sy = sc_up ? sc_y + 1'b1 : sc_y - 1'b1;
          sc_y_next = sc_up ? sc_y + 1'b1 : sc_y - 1'b1;
          w_ret_next = 1'b1;
          state_next = ST_W_RD;
        end else begin
          walk_next.dy = sc_end;
          walk_next.chr = BLANK_CHAR;
          walk_next.attr = '0;
          w_ret_next = 1'b0;
          state_next = ST_W_FILL;
        end
      end
      ST_W_RD: state_next = ST_W_WR;
      ST_W_WR, ST_W_FILL: begin
        if (walk.x == walk.xend) begin
          state_next = w_ret ? ST_SCROLL : ST_RUN;
        end else begin
          walk_next.x = walk.dec ? walk.x - 1'b1 : walk.x + 1'b1;
          walk_next.sx = walk.dec ? walk.sx - 1'b1 : walk.sx + 1'b1;
          state_next = (state == ST_W_WR) ? ST_W_RD : ST_W_FILL;
        end
      end
      ST_RD0: state_next = ST_RD1;
      ST_RD1: begin
        rd_char_next = mem_rdata[7:0];
        rd_attr_next = 8'(mem_rdata[DW-2:8]);
        rd_dirty_next = mem_rdata[DW-1];
        phase_next = PH_DONE;
        state_next = ST_RUN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE) || mem_busy;
    mem_re = (state == ST_W_RD) || (state == ST_RD0);
    mem_raddr = (state == ST_RD0) ? cell_addr(YW'(row_r), XW'(col_r))
                                  : cell_addr(walk.sy, walk.sx);
    mem_we = (state == ST_W_WR) || (state == ST_W_FILL) || (state == ST_RD1);
    mem_waddr = (state == ST_RD1) ? cell_addr(YW'(row_r), XW'(col_r))
                                  : cell_addr(walk.dy, walk.x);
    case (state)
      ST_W_WR: mem_wdata = {1'b1, mem_rdata[DW-2:0]};
      ST_RD1: mem_wdata = {1'b0, mem_rdata[DW-2:0]};
      default: mem_wdata = {1'b1, walk.attr, walk.chr};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cur_col <= '0;
      cur_line <= '0;
      rtop <= '0;
      rbot <= YW'(ROWS - 1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cur_col <= cur_col_next;
      cur_line <= cur_line_next;
      rtop <= rtop_next;
      rbot <= rbot_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    phase <= phase_next;
    cmd_r <= cmd_r_next;
    ch_r <= ch_r_next;
    av_r <= av_r_next;
    col_r <= col_r_next;
    row_r <= row_r_next;
    bot_r <= bot_r_next;
    cnt_r <= cnt_r_next;
    dir_r <= dir_r_next;
    opt_r <= opt_r_next;
    ucr_r <= ucr_r_next;
    ins_n <= ins_n_next;
    line_cnt <= line_cnt_next;
    sc_up <= sc_up_next;
    sc_y <= sc_y_next;
    sc_end <= sc_end_next;
    walk <= walk_next;
    w_ret <= w_ret_next;
    rd_char <= rd_char_next;
    rd_attr <= rd_attr_next;
    rd_dirty <= rd_dirty_next;
    out_col <= out_col_next;
    out_row <= out_row_next;
    out_char <= out_char_next;
    out_attr <= out_attr_next;
    out_dirty <= out_dirty_next;
  end

  assign cursor_column = 7'(out_col);
  assign cursor_row = 5'(out_row);
  assign cell_char = out_char;
  assign cell_attribute = out_attr;
  assign cell_dirty = out_dirty;

`ifndef ASSERT_OFF
  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted beat not followed by stall");
  a_no_write_in_clear: assert property (@(posedge clk) disable iff (rst)
    mem_busy |-> !mem_we)
    else $error("cell write during clearing sweep");
  a_line_range: assert property (@(posedge clk) disable iff (rst)
    cur_line <= YW'(ROWS - 1))
    else $error("cursor row out of grid");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    cur_col <= XW'(COLS))
    else $error("cursor column out of range");
  a_region_order: assert property (@(posedge clk) disable iff (rst)
    rtop < rbot)
    else $error("scroll region top not above bottom");
`endif

endmodule
`default_nettype wire

// File: src/text_cell_buffer_with_cursor.sv
// Top level of the character-cell terminal buffer: configuration registers and wiring.
`default_nettype none
// Terminal display buffer holding ROWS x COLS cells of {dirty, attribute, character} in
// one single-port-write memory with a registered read. After reset a clearing sweep
// zeroes the memory; no command beat is taken until it ends. Cursor-only commands
// are return, backspace, move, set position, set region and read of an out-of-range
// cell; tab is one too unless it wraps at the region bottom and scrolls. Cell moves
// go through the memory port as a read then a write per copied cell and a single
// write per blanked cell, so a scroll of a k-row region copies k-1 rows and blanks
// one, insert/delete lines repeat that count times, and insert/delete chars copy
// each shifted cell the same way. The result register holds one finished result
// while the next beat is taken.
module text_cell_buffer_with_cursor #(
  parameter int COLS = tcb_pkg::DEF_COLS,
  parameter int ROWS = tcb_pkg::DEF_ROWS,
  parameter int ATTR_BITS = tcb_pkg::DEF_ATTR_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [4:0] command,
  input  logic [7:0] char_code,
  input  logic [7:0] attribute_value,
  input  logic [7:0] column,
  input  logic [7:0] row,
  input  logic [7:0] bottom_row,
  input  logic [7:0] count,
  input  logic [1:0] direction,
  input  logic       option_flag,
  input  logic       use_cursor_row,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] cursor_column,
  output logic [4:0] cursor_row,
  output logic [7:0] cell_char,
  output logic [7:0] cell_attribute,
  output logic       cell_dirty
);
  import tcb_pkg::*;

  localparam int DEPTH = ROWS * COLS;
  localparam int AW = $clog2(DEPTH);
  localparam int DW = 9 + ATTR_BITS;

  logic          ins_mode;
  logic [7:0]    cur_attr;
  logic          mem_busy;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      ins_mode <= 1'b0;
      cur_attr <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_INSERT_MODE: ins_mode <= cfg_data[0];
        CFG_ATTRIBUTE: cur_attr <= cfg_data;
        default: ;
      endcase
    end
  end

  tcb_ctrl #(
    .COLS(COLS),
    .ROWS(ROWS),
    .ATTR_BITS(ATTR_BITS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .char_code(char_code),
    .attribute_value(attribute_value),
    .column(column),
    .row(row),
    .bottom_row(bottom_row),
    .count(count),
    .direction(direction),
    .option_flag(option_flag),
    .use_cursor_row(use_cursor_row),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cursor_column(cursor_column),
    .cursor_row(cursor_row),
    .cell_char(cell_char),
    .cell_attribute(cell_attribute),
    .cell_dirty(cell_dirty),
    .insert_mode(ins_mode),
    .current_attribute(cur_attr),
    .mem_busy(mem_busy),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re(mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  tcb_cell_mem #(
    .DEPTH(DEPTH),
    .DW(DW)
  ) u_mem (
    .clk(clk),
    .rst(rst),
    .busy(mem_busy),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule
`default_nettype wire

// File: bench/text_cell_buffer_with_cursor_test.sv
// Testbench for the text cell buffer: directed and random command beats checked against a behavioral predictor.
`timescale 1ns / 100ps
module text_cell_buffer_with_cursor_test;
  import tcb_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 24;
  localparam int NCELL = COLS * ROWS;
  localparam int IDLE_LIMIT = 4000000;

  typedef struct packed {
    logic [4:0] cmd;
    logic [7:0] ch;
    logic [7:0] av;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] bot;
    logic [7:0] cnt;
    logic [1:0] dir;
    logic opt;
    logic ucr;
  } cmd_beat_t;

  typedef struct packed {
    logic [6:0] ccol;
    logic [4:0] crow;
    logic [7:0] ch;
    logic [7:0] attr;
    logic dirty;
  } view_t;

  class screen_scoreboard;
    logic [7:0] chars [NCELL];
    logic [7:0] attrs [NCELL];
    bit dirty [NCELL];
    int cx, cy, top, bottom;
    bit ins_mode;
    logic [7:0] cur_attr;
    view_t pending [$];
    int errors;

    function void clear_all();
      for (int i = 0; i < NCELL; i++) begin
        chars[i] = 0; attrs[i] = 0; dirty[i] = 0;
      end
      cx = 0; cy = 0; top = 0; bottom = ROWS - 1;
      ins_mode = 0; cur_attr = 0; errors = 0;
    endfunction

    function void set_reg(bit idx, logic [7:0] v);
      if (idx == CFG_INSERT_MODE) ins_mode = v[0];
      else cur_attr = v;
    endfunction

    function void poke(int x, int y, logic [7:0] c, logic [7:0] a);
      if (x >= COLS || y >= ROWS) return;
      chars[y*COLS+x] = c; attrs[y*COLS+x] = a; dirty[y*COLS+x] = 1;
    endfunction

    function void dup(int sx, int sy, int dx, int dy);
      if (sx >= COLS || sy >= ROWS) return;
      poke(dx, dy, chars[sy*COLS+sx], attrs[sy*COLS+sx]);
    endfunction

    function void roll_up(int t, int b);
      for (int y = t + 1; y <= b; y++)
        for (int x = 0; x < COLS; x++) dup(x, y, x, y - 1);
      for (int x = 0; x < COLS; x++) poke(x, b, BLANK_CHAR, 0);
    endfunction

    function void roll_down(int t, int b);
      for (int y = b; y > t; y--)
        for (int x = 0; x < COLS; x++) dup(x, y - 1, x, y);
      for (int x = 0; x < COLS; x++) poke(x, t, BLANK_CHAR, 0);
    endfunction

    function void next_line();
      if (cy == bottom) roll_up(top, bottom);
      else if (cy < ROWS - 1) cy++;
      if (cx >= COLS) cx = COLS - 1;
    endfunction

    function void prev_line();
      if (cy == top) roll_down(top, bottom);
      else if (cy > 0) cy--;
      if (cx >= COLS) cx = COLS - 1;
    endfunction

    function void open_gap(int n);
      int c;
      c = cx;
      if (c >= COLS) return;
      if (n > COLS - c) n = COLS - c;
      for (int x = COLS - 1; x >= c + n; x--) dup(x - n, cy, x, cy);
      for (int x = c; x < c + n; x++) poke(x, cy, BLANK_CHAR, cur_attr);
    endfunction

    function void close_gap(int n);
      int c;
      c = cx;
      if (c >= COLS) return;
      if (n > COLS - c) n = COLS - c;
      for (int x = c; x + n < COLS; x++) dup(x + n, cy, x, cy);
      for (int x = COLS - n; x < COLS; x++) poke(x, cy, BLANK_CHAR, cur_attr);
    endfunction

    function int one_based(int v, int lim);
      int r;
      r = (v == 0) ? 0 : v - 1;
      return (r >= lim) ? lim - 1 : r;
    endfunction

    function void note_beat(cmd_beat_t b);
      view_t v;
      int n, t, y, lo, hi;
      v = '0;
      case (b.cmd)
        CMD_PUT: begin
          if (cx >= COLS) begin
            cx = 0; next_line();
          end
          if (ins_mode && !b.opt) open_gap(1);
          poke(cx, cy, b.ch, cur_attr);
          cx++;
        end
        CMD_PUT_AT: if (b.col < COLS && b.row < ROWS) begin
          if (ins_mode && !b.opt) open_gap(1);
          poke(b.col, b.row, b.ch, b.av);
        end
        CMD_CR: cx = 0;
        CMD_TAB: begin
          cx++;
          if (cx > COLS) begin
            cx = 0; next_line();
          end
          while (cx % 8 != 0) begin
            cx++;
            if (cx >= COLS) begin
              cx = 0; next_line();
            end
          end
        end
        CMD_BS: if (cx > 0) cx--;
        CMD_MOVE: begin
          n = (b.cnt == 0) ? 1 : b.cnt;
          if (cx >= COLS) cx = COLS - 1;
          case (b.dir)
            DIR_UP: cy = (n > cy) ? 0 : cy - n;
            DIR_DOWN: cy = (cy + n >= ROWS) ? ROWS - 1 : cy + n;
            DIR_LEFT: cx = (n > cx) ? 0 : cx - n;
            default: cx = (cx + n >= COLS) ? COLS - 1 : cx + n;
          endcase
        end
        CMD_SETPOS: begin
          cx = one_based(b.col, COLS); cy = one_based(b.row, ROWS);
        end
        CMD_LF: next_line();
        CMD_RLF: prev_line();
        CMD_REGION: begin
          t = (b.row == 0) ? 0 : b.row - 1;
          n = (b.bot == 0 || b.bot > ROWS) ? ROWS - 1 : b.bot - 1;
          if (t < n) begin
            top = t; bottom = n;
          end
          cx = 0; cy = 0;
        end
        CMD_INS_LINES: for (int i = 0; i < b.cnt; i++) roll_down(cy, ROWS - 1);
        CMD_DEL_LINES: for (int i = 0; i < b.cnt; i++) roll_up(cy, ROWS - 1);
        CMD_CLR_ROW: begin
          y = b.ucr ? cy : b.row;
          if (y < ROWS) begin
            lo = b.opt ? 0 : cx;
            hi = b.opt ? cx : COLS - 1;
            if (hi >= COLS) hi = COLS - 1;
            for (int x = lo; x <= hi; x++) poke(x, y, BLANK_CHAR, 0);
          end
        end
        CMD_DEL_CHARS: close_gap(b.cnt);
        CMD_ERASE: for (int x = cx; x < COLS && x < cx + b.cnt; x++)
          poke(x, cy, BLANK_CHAR, cur_attr);
        CMD_INS_CHARS: open_gap(b.cnt);
        CMD_READ: if (b.col < COLS && b.row < ROWS) begin
          n = b.row * COLS + b.col;
          v.ch = chars[n]; v.attr = attrs[n]; v.dirty = dirty[n];
          dirty[n] = 0;
        end
        default: ;
      endcase
      v.ccol = 7'(cx); v.crow = 5'(cy);
      pending.push_back(v);
    endfunction

    function void check_result(view_t got);
      view_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.ccol !== e.ccol) begin
        $error("cursor_column expected %0d got %0d", e.ccol, got.ccol); errors++;
      end
      if (got.crow !== e.crow) begin
        $error("cursor_row expected %0d got %0d", e.crow, got.crow); errors++;
      end
      if (got.ch !== e.ch) begin
        $error("cell_char expected %0h got %0h", e.ch, got.ch); errors++;
      end
      if (got.attr !== e.attr) begin
        $error("cell_attribute expected %0h got %0h", e.attr, got.attr); errors++;
      end
      if (got.dirty !== e.dirty) begin
        $error("cell_dirty expected %0b got %0b", e.dirty, got.dirty); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_write = 0;
  logic [0:0] cfg_index = 0;
  logic [7:0] cfg_data = 0;
  logic in_valid = 0, in_stall;
  cmd_beat_t beat = '0;
  logic out_valid, out_stall = 0;
  view_t seen;
  screen_scoreboard sb;
  int quiet_cycles = 0;
  int hold_off = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  text_cell_buffer_with_cursor DUT (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .command(beat.cmd), .char_code(beat.ch), .attribute_value(beat.av),
    .column(beat.col), .row(beat.row), .bottom_row(beat.bot), .count(beat.cnt),
    .direction(beat.dir), .option_flag(beat.opt), .use_cursor_row(beat.ucr),
    .out_valid(out_valid), .out_stall(out_stall),
    .cursor_column(seen.ccol), .cursor_row(seen.crow), .cell_char(seen.ch),
    .cell_attribute(seen.attr), .cell_dirty(seen.dirty)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && !out_stall) sb.check_result(seen);
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // receiver: random stall per beat, long hold-off on request
  initial begin
    int w;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_stall <= 1;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end
      w = $urandom_range(0, 1) ? 0 : $urandom_range(0, 4);
      if (w > 0) begin
        out_stall <= 1;
        repeat (w - 1) @(negedge clk);
        @(negedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  task automatic send(cmd_beat_t b, bit no_gap = 0);
    int w;
    w = no_gap ? 0 : $urandom_range(0, 4);
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(negedge clk);
    end
    beat <= b;
    in_valid <= 1;
    sb.note_beat(b);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 0;
    while (sb.pending.size() > 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(bit idx, logic [7:0] v);
    settle();
    cfg_write <= 1; cfg_index <= idx; cfg_data <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_write <= 0;
  endtask

  function automatic cmd_beat_t mk(logic [4:0] c);
    cmd_beat_t b;
    b = '0;
    b.cmd = c;
    return b;
  endfunction

  function automatic cmd_beat_t random_beat();
    cmd_beat_t b;
    int r;
    b = $bits(cmd_beat_t)'({$urandom, $urandom});
    r = $urandom_range(0, 99);
    if (r < 30) b.cmd = CMD_PUT;
    else if (r < 45) b.cmd = CMD_READ;
    else if (r < 48) b.cmd = 5'(17 + $urandom_range(0, 14));
    else b.cmd = 5'($urandom_range(1, 15));
    if ($urandom_range(0, 3) != 0) begin
      b.col = 8'($urandom_range(0, 90));
      b.row = 8'($urandom_range(0, 27));
      b.bot = 8'($urandom_range(0, 27));
    end
    if (b.cmd inside {CMD_INS_LINES, CMD_DEL_LINES})
      b.cnt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 2));
    else if ($urandom_range(0, 3) != 0) b.cnt = 8'($urandom_range(0, 12));
    return b;
  endfunction

  initial begin
    cmd_beat_t b;
    sb = new();
    sb.clear_all();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    write_reg(CFG_ATTRIBUTE, 8'hFF);
    b = mk(CMD_PUT); b.ch = 8'hFF; send(b);
    b = mk(CMD_PUT); b.ch = 8'h00; send(b);
    b = mk(CMD_SETPOS); b.col = 80; b.row = 24; send(b);
    b = mk(CMD_PUT); b.ch = 8'h41; send(b);
    send(mk(CMD_TAB));
    b = mk(CMD_SETPOS); b.col = 255; b.row = 0; send(b);
    send(mk(CMD_PUT)); send(mk(CMD_PUT));
    send(mk(CMD_ERASE)); send(mk(CMD_DEL_CHARS));
    b = mk(CMD_PUT_AT); b.col = 79; b.row = 23; b.av = 8'hAA; b.ch = 8'h55; send(b);
    b = mk(CMD_PUT_AT); b.col = 80; b.row = 0; send(b);
    b = mk(CMD_READ); b.col = 79; b.row = 23; send(b); send(b);
    b = mk(CMD_READ); b.col = 255; b.row = 255; send(b);
    b = mk(CMD_MOVE); b.dir = DIR_RIGHT; b.cnt = 255; send(b);
    b.dir = DIR_DOWN; b.cnt = 0; send(b);
    send(mk(CMD_LF)); send(mk(CMD_RLF)); send(mk(CMD_CR)); send(mk(CMD_BS));
    b = mk(CMD_REGION); b.row = 5; b.bot = 3; send(b);
    b = mk(CMD_REGION); b.row = 0; b.bot = 255; send(b);
    b = mk(CMD_CLR_ROW); b.ucr = 1; b.opt = 1; send(b);
    b = mk(CMD_INS_CHARS); b.cnt = 255; send(b);
    write_reg(CFG_INSERT_MODE, 1);
    b = mk(CMD_PUT_AT); b.col = 3; b.row = 2; b.ch = 8'h7E; send(b);

    // fill the block while the receiver holds off
    hold_off = 300;
    for (int i = 0; i < 20; i++) begin
      b = mk(CMD_PUT); b.ch = 8'($urandom); send(b, 1);
    end

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: write_reg(CFG_INSERT_MODE, 0);
        2: write_reg(CFG_ATTRIBUTE, 8'h00);
        3: write_reg(CFG_INSERT_MODE, 1);
        4: write_reg(CFG_ATTRIBUTE, 8'($urandom));
        default: ;
      endcase
      for (int i = 0; i < 145; i++) send(random_beat(), $urandom_range(0, 2) == 0);
    end

    settle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// File: sim.f
src/tcb_pkg.sv
src/tcb_cell_mem.sv
src/tcb_ctrl.sv
src/text_cell_buffer_with_cursor.sv
bench/text_cell_buffer_with_cursor_test.sv
